/* design/hcts_pkg.sv */
// Shared types and constants of the heterogeneous-core task scheduler.
`default_nettype none
package hcts_pkg;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  task_id;
		logic [15:0] arrival_cycle;
		logic [15:0] cpu_budget;
		logic [15:0] io_budget;
		logic [7:0]  task_priority;
		logic        declared_kind;
	} item_t;

	typedef struct packed {
		logic [3:0]  code;
		logic [7:0]  task_id;
		logic [2:0]  core;
		logic [15:0] value;
		logic [31:0] perf_total;
		logic [31:0] eff_total;
		logic        last;
	} event_t;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [3:0] EV_ADDED     = 4'd0;
	localparam logic [3:0] EV_FULL      = 4'd1;
	localparam logic [3:0] EV_ARRIVED   = 4'd2;
	localparam logic [3:0] EV_ENDED     = 4'd3;
	localparam logic [3:0] EV_TO_IO     = 4'd4;
	localparam logic [3:0] EV_IO_DONE   = 4'd5;
	localparam logic [3:0] EV_CLS_CPU   = 4'd6;
	localparam logic [3:0] EV_CLS_IO    = 4'd7;
	localparam logic [3:0] EV_ASSIGNED  = 4'd8;
	localparam logic [3:0] EV_TICK_END  = 4'd9;

	localparam logic [2:0] ST_EMPTY = 3'd0;
	localparam logic [2:0] ST_NEW   = 3'd1;
	localparam logic [2:0] ST_READY = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [1:0] KIND_CPU     = 2'd1;
	localparam logic [1:0] KIND_IO      = 2'd2;

	localparam logic [1:0] POL_NAIVE  = 2'd0;
	localparam logic [1:0] POL_STATIC = 2'd1;

	localparam logic [2:0]  IO_BURST  = 3'd5;
	localparam logic [2:0]  BURST_MAX = 3'd7;
	localparam logic [15:0] OBSERVE   = 16'd3;
	localparam logic [19:0] CLS_NUM   = 20'd10;
	localparam logic [19:0] CLS_DEN   = 20'd7;

endpackage
`default_nettype wire

/* design/hcts_fifo.sv */
// Small first-in first-out queue used between the scheduler's parts.
`default_nettype none
module hcts_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push,
	input  wire T wdata,
	output logic  full,
	input  wire   pop,
	output T      rdata,
	output logic  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	T               mem_q [DEPTH];
	logic [AW-1:0]  wp_q;
	logic [AW-1:0]  rp_q;
	logic [AW:0]    cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

/* design/hcts_engine.sv */
// Back part: task table, cores and the tick sequencer that emits event words.
`default_nettype none
module hcts_engine #(
	parameter int PERF_CORES = 2,
	parameter int EFF_CORES  = 2,
	parameter int MAX_TASKS  = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire [1:0]            policy,
	input  wire                  in_valid,
	input  wire hcts_pkg::item_t in_item,
	output logic                 in_pop,
	input  wire                  ev_full,
	output logic                 ev_push,
	output hcts_pkg::event_t     ev_data
);
	localparam int NCORES = PERF_CORES + EFF_CORES;
	localparam int NCA    = (NCORES > 0) ? NCORES : 1;
	localparam int CW     = (NCA > 1) ? $clog2(NCA) : 1;
	localparam int SW     = $clog2(MAX_TASKS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ARRIVE = 3'd1;
	localparam logic [2:0] S_CORE   = 3'd2;
	localparam logic [2:0] S_IOW    = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_PICK   = 3'd5;
	localparam logic [2:0] S_TEND   = 3'd6;

	logic [2:0]    state_q;
	logic [15:0]   cycle_q;
	logic [SW:0]   tcnt_q;
	logic [SW:0]   idx_q;
	logic [CW:0]   core_q;
	logic [31:0]   perf_q;
	logic [31:0]   eff_q;
	logic          c_busy_q [NCA];
	logic [SW-1:0] c_slot_q [NCA];

	logic [2:0]  status_q [MAX_TASKS];
	logic [7:0]  ident_q  [MAX_TASKS];
	logic [15:0] arr_q    [MAX_TASKS];
	logic [7:0]  prio_q   [MAX_TASKS];
	logic [15:0] ctot_q   [MAX_TASKS];
	logic [15:0] cdone_q  [MAX_TASKS];
	logic [15:0] itot_q   [MAX_TASKS];
	logic [15:0] idone_q  [MAX_TASKS];
	logic [15:0] ticks_q  [MAX_TASKS];
	logic [2:0]  burst_q  [MAX_TASKS];
	logic        skind_q  [MAX_TASKS];
	logic [1:0]  lkind_q  [MAX_TASKS];

	logic          have_last_q;
	logic [7:0]    last_p_q;
	logic [SW-1:0] last_s_q;
	logic          best_v_q;
	logic [7:0]    best_p_q;
	logic [SW-1:0] best_s_q;
	logic [SW-1:0] pick_q;

	logic [CW-1:0] cidx;
	logic [SW-1:0] rd;
	logic [SW-1:0] islot;
	logic          core_live;
	logic          core_perf;
	logic          slot_live;
	logic [15:0]   cd1;
	logic [15:0]   tr1;
	logic [15:0]   iod1;
	logic [2:0]    b1;
	logic          end_c;
	logic          io_c;
	logic [31:0]   perf_nx;
	logic [31:0]   eff_nx;
	logic          cls_need;
	logic          cls_cpu;
	logic [19:0]   m_cd;
	logic [19:0]   m_tr;
	logic          cand;
	logic          tab_full;

	logic          f_perf_v;
	logic          f_eff_v;
	logic          f_any_v;
	logic [CW-1:0] f_perf;
	logic [CW-1:0] f_eff;
	logic [CW-1:0] f_any;
	logic          sel_v;
	logic [CW-1:0] sel_c;

	logic          emit;
	logic          adv;

	assign cidx      = core_q[CW-1:0];
	assign islot     = idx_q[SW-1:0];
	assign rd        = (state_q == S_CORE) ? c_slot_q[cidx] :
	                   (state_q == S_PICK) ? pick_q : islot;
	assign core_live = (core_q < (CW+1)'(NCORES));
	assign core_perf = (core_q < (CW+1)'(PERF_CORES));
	assign slot_live = (idx_q < tcnt_q);
	assign tab_full  = (tcnt_q == (SW+1)'(MAX_TASKS));

	assign cd1  = (cdone_q[rd] == 16'hFFFF) ? cdone_q[rd] : cdone_q[rd] + 16'd1;
	assign tr1  = (ticks_q[rd] == 16'hFFFF) ? ticks_q[rd] : ticks_q[rd] + 16'd1;
	assign iod1 = (idone_q[rd] == 16'hFFFF) ? idone_q[rd] : idone_q[rd] + 16'd1;
	assign b1   = (burst_q[rd] < hcts_pkg::BURST_MAX) ? burst_q[rd] + 3'd1 : burst_q[rd];

	assign end_c = (cd1 >= ctot_q[rd]);
	assign io_c  = !end_c && (idone_q[rd] < itot_q[rd]) && (b1 >= hcts_pkg::IO_BURST);

	assign perf_nx = core_perf ? perf_q + 32'd1 : perf_q;
	assign eff_nx  = core_perf ? eff_q : eff_q + 32'd1;

	// Classification uses the integer form of the 0.7 CPU share threshold.
	assign m_cd     = 20'(cdone_q[rd]) * hcts_pkg::CLS_NUM;
	assign m_tr     = 20'(ticks_q[rd]) * hcts_pkg::CLS_DEN;
	assign cls_cpu  = (m_cd > m_tr);
	assign cls_need = (policy != hcts_pkg::POL_NAIVE) && (policy != hcts_pkg::POL_STATIC) &&
	                  (lkind_q[rd] == hcts_pkg::KIND_UNKNOWN) && (ticks_q[rd] > hcts_pkg::OBSERVE);

	// A ready slot is a candidate when its (priority, slot) key follows the last pick.
	assign cand = (status_q[rd] == hcts_pkg::ST_READY) &&
	              (!have_last_q || (prio_q[rd] > last_p_q) ||
	               ((prio_q[rd] == last_p_q) && (islot > last_s_q)));

	always_comb begin
		f_perf_v = 1'b0;
		f_eff_v  = 1'b0;
		f_any_v  = 1'b0;
		f_perf   = '0;
		f_eff    = '0;
		f_any    = '0;
		for (int c = NCA - 1; c >= 0; c--) begin
			if ((c < NCORES) && !c_busy_q[c]) begin
				f_any_v = 1'b1;
				f_any   = CW'(c);
				if (c < PERF_CORES) begin
					f_perf_v = 1'b1;
					f_perf   = CW'(c);
				end else begin
					f_eff_v = 1'b1;
					f_eff   = CW'(c);
				end
			end
		end
	end

	always_comb begin
		sel_v = 1'b0;
		sel_c = '0;
		case (policy)
			hcts_pkg::POL_NAIVE: begin
				sel_v = f_any_v;
				sel_c = f_any;
			end
			hcts_pkg::POL_STATIC: begin
				sel_v = skind_q[rd] ? f_eff_v : f_perf_v;
				sel_c = skind_q[rd] ? f_eff : f_perf;
			end
			default: begin
				if (lkind_q[rd] == hcts_pkg::KIND_CPU && f_perf_v) begin
					sel_v = 1'b1;
					sel_c = f_perf;
				end else if (lkind_q[rd] != hcts_pkg::KIND_CPU && f_eff_v) begin
					sel_v = 1'b1;
					sel_c = f_eff;
				end else begin
					sel_v = f_any_v;
					sel_c = f_any;
				end
			end
		endcase
	end

	always_comb begin
		emit               = 1'b0;
		ev_data            = '0;
		ev_data.perf_total = perf_q;
		ev_data.eff_total  = eff_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_item.req_type == hcts_pkg::REQ_ADD) begin
					emit            = 1'b1;
					ev_data.code    = tab_full ? hcts_pkg::EV_FULL : hcts_pkg::EV_ADDED;
					ev_data.task_id = in_item.task_id;
					ev_data.last    = 1'b1;
				end
			end
			S_ARRIVE: begin
				if (slot_live && status_q[rd] == hcts_pkg::ST_NEW && arr_q[rd] == cycle_q) begin
					emit            = 1'b1;
					ev_data.code    = hcts_pkg::EV_ARRIVED;
					ev_data.task_id = ident_q[rd];
				end
			end
			S_CORE: begin
				if (core_live && c_busy_q[cidx] && (end_c || io_c)) begin
					emit               = 1'b1;
					ev_data.code       = end_c ? hcts_pkg::EV_ENDED : hcts_pkg::EV_TO_IO;
					ev_data.task_id    = ident_q[rd];
					ev_data.core       = 3'(cidx);
					ev_data.value      = end_c ? cycle_q + 16'd1 - arr_q[rd] : 16'd0;
					ev_data.perf_total = perf_nx;
					ev_data.eff_total  = eff_nx;
				end
			end
			S_IOW: begin
				if (slot_live && status_q[rd] == hcts_pkg::ST_WAIT && iod1 >= itot_q[rd]) begin
					emit            = 1'b1;
					ev_data.code    = hcts_pkg::EV_IO_DONE;
					ev_data.task_id = ident_q[rd];
				end
			end
			S_PICK: begin
				if (cls_need) begin
					emit            = 1'b1;
					ev_data.code    = cls_cpu ? hcts_pkg::EV_CLS_CPU : hcts_pkg::EV_CLS_IO;
					ev_data.task_id = ident_q[rd];
				end else if (sel_v) begin
					emit            = 1'b1;
					ev_data.code    = hcts_pkg::EV_ASSIGNED;
					ev_data.task_id = ident_q[rd];
					ev_data.core    = 3'(sel_c);
				end
			end
			S_TEND: begin
				emit          = 1'b1;
				ev_data.code  = hcts_pkg::EV_TICK_END;
				ev_data.value = cycle_q;
				ev_data.last  = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign adv     = !emit || !ev_full;
	assign ev_push = emit && !ev_full;
	assign in_pop  = (state_q == S_IDLE) && in_valid && adv;

	// Per-slot payload; only slots below the task count are ever read.
	always_ff @(posedge clk) begin
		if (adv) begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_item.req_type == hcts_pkg::REQ_ADD && !tab_full) begin
						ident_q[tcnt_q[SW-1:0]] <= in_item.task_id;
						arr_q[tcnt_q[SW-1:0]]   <= in_item.arrival_cycle;
						ctot_q[tcnt_q[SW-1:0]]  <= in_item.cpu_budget;
						itot_q[tcnt_q[SW-1:0]]  <= in_item.io_budget;
						prio_q[tcnt_q[SW-1:0]]  <= in_item.task_priority;
						skind_q[tcnt_q[SW-1:0]] <= in_item.declared_kind;
						cdone_q[tcnt_q[SW-1:0]] <= '0;
						idone_q[tcnt_q[SW-1:0]] <= '0;
						ticks_q[tcnt_q[SW-1:0]] <= '0;
						burst_q[tcnt_q[SW-1:0]] <= '0;
						lkind_q[tcnt_q[SW-1:0]] <= hcts_pkg::KIND_UNKNOWN;
					end
				end
				S_CORE: begin
					if (core_live && c_busy_q[cidx]) begin
						cdone_q[rd] <= cd1;
						ticks_q[rd] <= tr1;
						burst_q[rd] <= io_c ? 3'd0 : b1;
					end
				end
				S_IOW: begin
					if (slot_live && status_q[rd] == hcts_pkg::ST_WAIT) begin
						idone_q[rd] <= iod1;
					end
				end
				S_PICK: begin
					if (cls_need) begin
						lkind_q[rd] <= cls_cpu ? hcts_pkg::KIND_CPU : hcts_pkg::KIND_IO;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cycle_q     <= '0;
			tcnt_q      <= '0;
			idx_q       <= '0;
			core_q      <= '0;
			perf_q      <= '0;
			eff_q       <= '0;
			have_last_q <= 1'b0;
			last_p_q    <= '0;
			last_s_q    <= '0;
			best_v_q    <= 1'b0;
			best_p_q    <= '0;
			best_s_q    <= '0;
			pick_q      <= '0;
			for (int c = 0; c < NCA; c++) begin
				c_busy_q[c] <= 1'b0;
				c_slot_q[c] <= '0;
			end
			for (int s = 0; s < MAX_TASKS; s++) begin
				status_q[s] <= hcts_pkg::ST_EMPTY;
			end
		end else if (adv) begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_item.req_type == hcts_pkg::REQ_TICK) begin
							idx_q   <= '0;
							state_q <= S_ARRIVE;
						end else if (!tab_full) begin
							status_q[tcnt_q[SW-1:0]] <= hcts_pkg::ST_NEW;
							tcnt_q <= tcnt_q + 1'b1;
						end
					end
				end
				S_ARRIVE: begin
					if (slot_live) begin
						if (emit) begin
							status_q[rd] <= hcts_pkg::ST_READY;
						end
						idx_q <= idx_q + 1'b1;
					end else begin
						core_q  <= '0;
						state_q <= S_CORE;
					end
				end
				S_CORE: begin
					if (core_live) begin
						if (c_busy_q[cidx]) begin
							perf_q <= perf_nx;
							eff_q  <= eff_nx;
							if (end_c) begin
								status_q[rd]   <= hcts_pkg::ST_DONE;
								c_busy_q[cidx] <= 1'b0;
							end else if (io_c) begin
								status_q[rd]   <= hcts_pkg::ST_WAIT;
								c_busy_q[cidx] <= 1'b0;
							end
						end
						core_q <= core_q + 1'b1;
					end else begin
						idx_q   <= '0;
						state_q <= S_IOW;
					end
				end
				S_IOW: begin
					if (slot_live) begin
						if (emit) begin
							status_q[rd] <= hcts_pkg::ST_READY;
						end
						idx_q <= idx_q + 1'b1;
					end else begin
						idx_q       <= '0;
						have_last_q <= 1'b0;
						best_v_q    <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (slot_live) begin
						if (cand && (!best_v_q || prio_q[rd] < best_p_q)) begin
							best_v_q <= 1'b1;
							best_p_q <= prio_q[rd];
							best_s_q <= islot;
						end
						idx_q <= idx_q + 1'b1;
					end else if (best_v_q) begin
						pick_q      <= best_s_q;
						have_last_q <= 1'b1;
						last_p_q    <= best_p_q;
						last_s_q    <= best_s_q;
						state_q     <= S_PICK;
					end else begin
						state_q <= S_TEND;
					end
				end
				S_PICK: begin
					if (!cls_need) begin
						if (sel_v) begin
							c_busy_q[sel_c] <= 1'b1;
							c_slot_q[sel_c] <= pick_q;
							status_q[rd]    <= hcts_pkg::ST_RUN;
						end
						idx_q    <= '0;
						best_v_q <= 1'b0;
						state_q  <= S_SCAN;
					end
				end
				S_TEND: begin
					cycle_q <= cycle_q + 16'd1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* design/hetero_core_task_scheduler_unit.sv */
// An add word's event passes from the input queue through the engine and the event queue
// to the result ports; the engine takes words only while idle and stalls on a full event queue.
// A tick walks arrivals, cores and I/O waits over the table, then one task table scan per pick.
// A two-entry input queue and a four-entry event queue decouple both sides.
// Reset clears the cycle count, task count, all statuses, cores, busy totals
// and the policy register.
`default_nettype none
module hetero_core_task_scheduler_unit #(
	parameter int PERF_CORES = 2,
	parameter int EFF_CORES  = 2,
	parameter int MAX_TASKS  = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         push,
	output logic        full,
	input  wire         req_type,
	input  wire  [7:0]  task_id,
	input  wire  [15:0] arrival_cycle,
	input  wire  [15:0] cpu_budget,
	input  wire  [15:0] io_budget,
	input  wire  [7:0]  task_priority,
	input  wire         declared_kind,
	output logic        empty,
	input  wire         pop,
	output logic [3:0]  event_code,
	output logic [7:0]  event_task,
	output logic [2:0]  event_core,
	output logic [15:0] event_value,
	output logic [31:0] perf_busy_total,
	output logic [31:0] eff_busy_total,
	output logic        last
);
	logic [1:0]        policy_q;
	hcts_pkg::item_t   in_w;
	hcts_pkg::item_t   in_head;
	logic              in_empty;
	logic              in_pop;
	hcts_pkg::event_t  ev_w;
	hcts_pkg::event_t  ev_head;
	logic              ev_push;
	logic              ev_full;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {30'd0, policy_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= hcts_pkg::POL_NAIVE;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			policy_q <= pwdata[1:0];
		end
	end

	assign in_w.req_type      = req_type;
	assign in_w.task_id       = task_id;
	assign in_w.arrival_cycle = arrival_cycle;
	assign in_w.cpu_budget    = cpu_budget;
	assign in_w.io_budget     = io_budget;
	assign in_w.task_priority = task_priority;
	assign in_w.declared_kind = declared_kind;

	hcts_fifo #(.T(hcts_pkg::item_t), .DEPTH(2)) u_inq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_w),
		.full   (full),
		.pop    (in_pop),
		.rdata  (in_head),
		.empty  (in_empty)
	);

	hcts_engine #(
		.PERF_CORES (PERF_CORES),
		.EFF_CORES  (EFF_CORES),
		.MAX_TASKS  (MAX_TASKS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.policy   (policy_q),
		.in_valid (!in_empty),
		.in_item  (in_head),
		.in_pop   (in_pop),
		.ev_full  (ev_full),
		.ev_push  (ev_push),
		.ev_data  (ev_w)
	);

	hcts_fifo #(.T(hcts_pkg::event_t), .DEPTH(4)) u_evq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ev_push),
		.wdata  (ev_w),
		.full   (ev_full),
		.pop    (pop),
		.rdata  (ev_head),
		.empty  (empty)
	);

	assign event_code      = ev_head.code;
	assign event_task      = ev_head.task_id;
	assign event_core      = ev_head.core;
	assign event_value     = ev_head.value;
	assign perf_busy_total = ev_head.perf_total;
	assign eff_busy_total  = ev_head.eff_total;
	assign last            = ev_head.last;
endmodule
`default_nettype wire

/* dv/scheduler_checker.sv */
// Checker for the task scheduler: tracks its own copy of the scheduler state and checks every event word.
`timescale 1ns / 1ps
module scheduler_checker #(
	parameter logic [2:0] POLICY_ADDR = 3'd0
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	input  wire         pready,
	input  wire         push,
	input  wire         full,
	input  wire         req_type,
	input  wire  [7:0]  task_id,
	input  wire  [15:0] arrival_cycle,
	input  wire  [15:0] cpu_budget,
	input  wire  [15:0] io_budget,
	input  wire  [7:0]  task_priority,
	input  wire         declared_kind,
	input  wire         empty,
	input  wire         pop,
	input  wire  [3:0]  event_code,
	input  wire  [7:0]  event_task,
	input  wire  [2:0]  event_core,
	input  wire  [15:0] event_value,
	input  wire  [31:0] perf_busy_total,
	input  wire  [31:0] eff_busy_total,
	input  wire         last,
	output int          fails,
	output int          pending
);
	localparam int NPERF  = 2;
	localparam int NCORES = 4;
	localparam int NSLOTS = 16;

	hcts_pkg::event_t expected_events[$];
	logic [1:0]  policy_r;
	logic [15:0] cycle_r;
	int          stored;
	logic [2:0]  status[NSLOTS];
	logic [7:0]  ident[NSLOTS];
	logic [15:0] arrival[NSLOTS];
	logic [7:0]  prio[NSLOTS];
	logic [15:0] cpu_need[NSLOTS];
	logic [15:0] cpu_used[NSLOTS];
	logic [15:0] io_need[NSLOTS];
	logic [15:0] io_used[NSLOTS];
	logic [15:0] ran[NSLOTS];
	logic [2:0]  burst[NSLOTS];
	logic        static_io[NSLOTS];
	logic [1:0]  learned[NSLOTS];
	logic        core_busy[NCORES];
	int          core_task[NCORES];
	logic [31:0] perf_ticks;
	logic [31:0] eff_ticks;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fails++;
	endtask

	function automatic logic [15:0] bump16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// want: 0 performance, 1 efficiency, 2 any kind. Returns -1 when none is idle.
	function automatic int idle_core(input int want);
		for (int c = 0; c < NCORES; c++) begin
			if (core_busy[c]) continue;
			if (want == 2 || ((want == 0) == (c < NPERF))) return c;
		end
		return -1;
	endfunction

	task automatic queue_event(input logic [3:0] code, input logic [7:0] id,
			input int core, input logic [15:0] value);
		hcts_pkg::event_t e;
		e.code = code;
		e.task_id = id;
		e.core = 3'(core);
		e.value = value;
		e.perf_total = perf_ticks;
		e.eff_total = eff_ticks;
		e.last = 1'b0;
		expected_events.insert(expected_events.size(), e);
	endtask

	task automatic start_task(input int s, input int c);
		core_busy[c] = 1'b1;
		core_task[c] = s;
		status[s] = hcts_pkg::ST_RUN;
		queue_event(hcts_pkg::EV_ASSIGNED, ident[s], c, 16'd0);
	endtask

	task automatic run_tick();
		int ready_order[$];
		int k;
		int s;
		int core;
		for (int i = 0; i < stored; i++)
			if (status[i] == hcts_pkg::ST_NEW && arrival[i] == cycle_r) begin
				status[i] = hcts_pkg::ST_READY;
				queue_event(hcts_pkg::EV_ARRIVED, ident[i], 0, 16'd0);
			end
		for (int c = 0; c < NCORES; c++) begin
			if (!core_busy[c]) continue;
			s = core_task[c];
			cpu_used[s] = bump16(cpu_used[s]);
			ran[s] = bump16(ran[s]);
			if (burst[s] < hcts_pkg::BURST_MAX) burst[s] = burst[s] + 3'd1;
			if (c < NPERF) perf_ticks++; else eff_ticks++;
			if (cpu_used[s] >= cpu_need[s]) begin
				status[s] = hcts_pkg::ST_DONE;
				core_busy[c] = 1'b0;
				queue_event(hcts_pkg::EV_ENDED, ident[s], c,
					16'(cycle_r + 16'd1 - arrival[s]));
			end else if (io_used[s] < io_need[s] && burst[s] >= hcts_pkg::IO_BURST) begin
				status[s] = hcts_pkg::ST_WAIT;
				burst[s] = 3'd0;
				core_busy[c] = 1'b0;
				queue_event(hcts_pkg::EV_TO_IO, ident[s], c, 16'd0);
			end
		end
		for (int i = 0; i < stored; i++)
			if (status[i] == hcts_pkg::ST_WAIT) begin
				io_used[i] = bump16(io_used[i]);
				if (io_used[i] >= io_need[i]) begin
					status[i] = hcts_pkg::ST_READY;
					queue_event(hcts_pkg::EV_IO_DONE, ident[i], 0, 16'd0);
				end
			end
		// Equal priorities keep table order.
		for (int i = 0; i < stored; i++) begin
			if (status[i] != hcts_pkg::ST_READY) continue;
			k = ready_order.size();
			while (k > 0 && prio[ready_order[k-1]] > prio[i]) k--;
			ready_order.insert(k, i);
		end
		if (policy_r == hcts_pkg::POL_NAIVE) begin
			k = 0;
			for (int c = 0; c < NCORES; c++)
				if (!core_busy[c] && k < ready_order.size()) begin
					start_task(ready_order[k], c);
					k++;
				end
		end else if (policy_r == hcts_pkg::POL_STATIC) begin
			foreach (ready_order[i]) begin
				core = idle_core(static_io[ready_order[i]] ? 1 : 0);
				if (core >= 0) start_task(ready_order[i], core);
			end
		end else begin
			foreach (ready_order[i]) begin
				s = ready_order[i];
				if (learned[s] == hcts_pkg::KIND_UNKNOWN && ran[s] > hcts_pkg::OBSERVE) begin
					if (32'(cpu_used[s]) * 32'(hcts_pkg::CLS_NUM) >
							32'(ran[s]) * 32'(hcts_pkg::CLS_DEN)) begin
						learned[s] = hcts_pkg::KIND_CPU;
						queue_event(hcts_pkg::EV_CLS_CPU, ident[s], 0, 16'd0);
					end else begin
						learned[s] = hcts_pkg::KIND_IO;
						queue_event(hcts_pkg::EV_CLS_IO, ident[s], 0, 16'd0);
					end
				end
				core = idle_core(learned[s] == hcts_pkg::KIND_CPU ? 0 : 1);
				if (core < 0) core = idle_core(2);
				if (core >= 0) start_task(s, core);
			end
		end
		queue_event(hcts_pkg::EV_TICK_END, 8'd0, 0, cycle_r);
		cycle_r = cycle_r + 16'd1;
	endtask

	task automatic predict_word();
		if (req_type == hcts_pkg::REQ_TICK) begin
			run_tick();
		end else if (stored >= NSLOTS) begin
			queue_event(hcts_pkg::EV_FULL, task_id, 0, 16'd0);
		end else begin
			status[stored] = hcts_pkg::ST_NEW;
			ident[stored] = task_id;
			arrival[stored] = arrival_cycle;
			cpu_need[stored] = cpu_budget;
			io_need[stored] = io_budget;
			prio[stored] = task_priority;
			static_io[stored] = declared_kind;
			cpu_used[stored] = 16'd0;
			io_used[stored] = 16'd0;
			ran[stored] = 16'd0;
			burst[stored] = 3'd0;
			learned[stored] = hcts_pkg::KIND_UNKNOWN;
			stored++;
			queue_event(hcts_pkg::EV_ADDED, task_id, 0, 16'd0);
		end
		expected_events[expected_events.size() - 1].last = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic check_word();
		hcts_pkg::event_t want;
		if (expected_events.size() == 0) begin
			report_mismatch($sformatf("unexpected word code %0d task %0d",
				event_code, event_task));
		end else begin
			want = expected_events.pop_front();
			check_field("event_code", 32'(event_code), 32'(want.code));
			check_field("event_task", 32'(event_task), 32'(want.task_id));
			check_field("event_core", 32'(event_core), 32'(want.core));
			check_field("event_value", 32'(event_value), 32'(want.value));
			check_field("perf_busy_total", perf_busy_total, want.perf_total);
			check_field("eff_busy_total", eff_busy_total, want.eff_total);
			check_field("last", 32'(last), 32'(want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_events.delete();
			fails = 0;
			policy_r = hcts_pkg::POL_NAIVE;
			cycle_r = 16'd0;
			stored = 0;
			perf_ticks = 32'd0;
			eff_ticks = 32'd0;
			for (int i = 0; i < NSLOTS; i++) status[i] = hcts_pkg::ST_EMPTY;
			for (int c = 0; c < NCORES; c++) core_busy[c] = 1'b0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == POLICY_ADDR)
				policy_r = pwdata[1:0];
			if (pop && !empty) check_word();
			if (push && !full) predict_word();
			pending = expected_events.size();
		end
	end
endmodule

/* dv/testbench.sv */
// Top of the task scheduler testbench: clock, reset, stimulus, result draining and verdict.
`timescale 1ns / 1ps
module testbench;

	localparam logic [2:0] POLICY_ADDR      = 3'd0;
	localparam logic [1:0] POL_ADAPTIVE     = 2'd2;
	localparam logic [1:0] POL_ADAPTIVE_ALT = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 400;
	localparam int HOLD_CYCLES    = 500;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	logic        full;
	logic        req_type = hcts_pkg::REQ_ADD;
	logic [7:0]  task_id = 8'd0;
	logic [15:0] arrival_cycle = 16'd0;
	logic [15:0] cpu_budget = 16'd0;
	logic [15:0] io_budget = 16'd0;
	logic [7:0]  task_priority = 8'd0;
	logic        declared_kind = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [3:0]  event_code;
	logic [7:0]  event_task;
	logic [2:0]  event_core;
	logic [15:0] event_value;
	logic [31:0] perf_busy_total;
	logic [31:0] eff_busy_total;
	logic        last;
	int          fails;
	int          pending;
	int          ticks_sent = 0;
	int          idle_cycles = 0;
	int          hold_requests = 0;

	always #5 clk = ~clk;

	hetero_core_task_scheduler_unit dut (.*);

	scheduler_checker #(.POLICY_ADDR(POLICY_ADDR)) u_checker (.*);

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result side: mostly ready, short stalls, now and then a long one.
	initial begin
		int r;
		int holds_done;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			if (hold_requests != holds_done) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			r = $urandom_range(0, 19);
			if (r < 13) begin
				pop <= 1'b1;
				@(posedge clk);
			end else begin
				pop <= 1'b0;
				repeat (r < 19 ? $urandom_range(1, 3) : $urandom_range(15, 60)) @(posedge clk);
			end
		end
	end

	task automatic write_policy(input logic [1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= POLICY_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_word(input logic rt, input logic [7:0] id, input logic [15:0] arr,
			input logic [15:0] cpu, input logic [15:0] io, input logic [7:0] pr,
			input logic kind);
		int r;
		int gap;
		req_type <= rt;
		task_id <= id;
		arrival_cycle <= arr;
		cpu_budget <= cpu;
		io_budget <= io;
		task_priority <= pr;
		declared_kind <= kind;
		push <= 1'b1;
		do @(posedge clk); while (full);
		if (rt == hcts_pkg::REQ_TICK) ticks_sent++;
		r = $urandom_range(0, 19);
		gap = (r < 10) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(20, 60);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_tick();
		send_word(hcts_pkg::REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic send_random_task();
		logic [15:0] arr;
		logic [15:0] cpu;
		logic [15:0] io;
		arr = ($urandom_range(0, 4) == 0) ? 16'($urandom)
			: 16'(ticks_sent + $urandom_range(0, 6));
		cpu = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 30));
		io = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
		send_word(hcts_pkg::REQ_ADD, 8'($urandom), arr, cpu, io, 8'($urandom), 1'($urandom));
	endtask

	task automatic random_phase(input int words, input int add_percent);
		repeat (words) begin
			if ($urandom_range(0, 99) < add_percent) send_random_task();
			else send_tick();
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_policy(hcts_pkg::POL_NAIVE);
		// Zero CPU budget ends after one tick; huge budgets stay alive for the whole run.
		send_word(hcts_pkg::REQ_ADD, 8'd0, 16'd0, 16'd0, 16'd0, 8'd255, 1'b0);
		send_word(hcts_pkg::REQ_ADD, 8'd255, 16'd0, 16'hFFFF, 16'hFFFF, 8'd255, 1'b1);
		send_word(hcts_pkg::REQ_ADD, 8'd17, 16'd1, 16'd12, 16'd3, 8'd0, 1'b1);
		send_word(hcts_pkg::REQ_ADD, 8'd34, 16'd1, 16'd7, 16'd0, 8'd0, 1'b0);
		send_word(hcts_pkg::REQ_ADD, 8'd51, 16'hFFFF, 16'd3, 16'd2, 8'd128, 1'b1);
		send_word(hcts_pkg::REQ_ADD, 8'd68, 16'd2, 16'hFFFF, 16'd2, 8'd5, 1'b0);
		repeat (4) send_tick();
		// Arrival already in the past: this task never becomes ready.
		send_word(hcts_pkg::REQ_ADD, 8'd85, 16'd0, 16'd4, 16'd1, 8'd1, 1'b0);
		send_word(hcts_pkg::REQ_ADD, 8'd102, 16'(ticks_sent + 1), 16'd40, 16'd6, 8'd2, 1'b1);
		repeat (9) send_tick();
		drain();

		write_policy(hcts_pkg::POL_STATIC);
		random_phase(35, 20);
		drain();

		write_policy(POL_ADAPTIVE);
		hold_requests++;
		random_phase(40, 12);
		drain();

		write_policy(POL_ADAPTIVE_ALT);
		random_phase(35, 10);
		drain();

		write_policy(hcts_pkg::POL_NAIVE);
		random_phase(35, 10);
		drain();

		if (fails == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
